### sv/stt_pkg.sv
// stt_pkg: shared constants, codes and helper functions of the source text tokenizer
`default_nettype none
package stt_pkg;

	localparam int KEYWORD_CHARS_DEF = 8;
	localparam int OFFSET_BITS_DEF   = 24;
	localparam int LINE_BITS_DEF     = 20;
	localparam int LENGTH_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH       = 4;

	localparam int KIND_W = 5;
	localparam int MODE_W = 4;

	localparam logic [MODE_W-1:0] M_IDLE  = 4'd0;
	localparam logic [MODE_W-1:0] M_IDENT = 4'd1;
	localparam logic [MODE_W-1:0] M_INT   = 4'd2;
	localparam logic [MODE_W-1:0] M_DOT   = 4'd3;
	localparam logic [MODE_W-1:0] M_FRAC  = 4'd4;
	localparam logic [MODE_W-1:0] M_STR   = 4'd5;
	localparam logic [MODE_W-1:0] M_CMT   = 4'd6;
	localparam logic [MODE_W-1:0] M_SLASH = 4'd7;
	localparam logic [MODE_W-1:0] M_EQ    = 4'd8;
	localparam logic [MODE_W-1:0] M_BANG  = 4'd9;
	localparam logic [MODE_W-1:0] M_LT    = 4'd10;
	localparam logic [MODE_W-1:0] M_GT    = 4'd11;

	localparam logic [KIND_W-1:0] K_END    = 5'd0;
	localparam logic [KIND_W-1:0] K_ID     = 5'd1;
	localparam logic [KIND_W-1:0] K_NUM    = 5'd2;
	localparam logic [KIND_W-1:0] K_STR    = 5'd3;
	localparam logic [KIND_W-1:0] K_PLUS   = 5'd4;
	localparam logic [KIND_W-1:0] K_MINUS  = 5'd5;
	localparam logic [KIND_W-1:0] K_STAR   = 5'd6;
	localparam logic [KIND_W-1:0] K_DIV    = 5'd7;
	localparam logic [KIND_W-1:0] K_ASSIGN = 5'd8;
	localparam logic [KIND_W-1:0] K_EQ     = 5'd9;
	localparam logic [KIND_W-1:0] K_NE     = 5'd10;
	localparam logic [KIND_W-1:0] K_LT     = 5'd11;
	localparam logic [KIND_W-1:0] K_GT     = 5'd12;
	localparam logic [KIND_W-1:0] K_LE     = 5'd13;
	localparam logic [KIND_W-1:0] K_GE     = 5'd14;
	localparam logic [KIND_W-1:0] K_LPAREN = 5'd15;
	localparam logic [KIND_W-1:0] K_RPAREN = 5'd16;
	localparam logic [KIND_W-1:0] K_LBRACE = 5'd17;
	localparam logic [KIND_W-1:0] K_RBRACE = 5'd18;
	localparam logic [KIND_W-1:0] K_LBRACK = 5'd19;
	localparam logic [KIND_W-1:0] K_RBRACK = 5'd20;
	localparam logic [KIND_W-1:0] K_SEMI   = 5'd21;
	localparam logic [KIND_W-1:0] K_COMMA  = 5'd22;
	localparam logic [KIND_W-1:0] K_ERR    = 5'd30;

	localparam int KW_COUNT = 7;
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		{"if", 48'h0}, {"else", 32'h0}, {"for", 40'h0}, {"while", 24'h0},
		{"function"}, {"return", 16'h0}, {"print", 24'h0}
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6, 4'd5};
	localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] =
		'{5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29};

	// text holds the first character in its top byte
	function automatic logic [KIND_W-1:0] kw_lookup(input logic [63:0] text,
		input logic [3:0] len);
		logic [KIND_W-1:0] kind;
		logic [63:0]       mask;
		kind = K_ID;
		mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {len, 3'b000});
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (len == KW_LEN[k] && ((text ^ KW_TEXT[k]) & mask) == 64'h0) begin
				kind = KW_KIND[k];
			end
		end
		return kind;
	endfunction

	// zero when the byte is no single-character operator
	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
		logic [KIND_W-1:0] kind;
		unique case (c)
			"+": kind = K_PLUS;
			"-": kind = K_MINUS;
			"*": kind = K_STAR;
			"(": kind = K_LPAREN;
			")": kind = K_RPAREN;
			"{": kind = K_LBRACE;
			"}": kind = K_RBRACE;
			"[": kind = K_LBRACK;
			"]": kind = K_RBRACK;
			";": kind = K_SEMI;
			",": kind = K_COMMA;
			default: kind = K_END;
		endcase
		return kind;
	endfunction

endpackage
`default_nettype wire

### sv/stt_if.sv
// stt_if: request and token channel interfaces of the source text tokenizer
`default_nettype none
interface stt_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_byte;

	modport source (output valid, req_type, char_byte, input ready);
	modport sink (input valid, req_type, char_byte, output ready);
endinterface

interface stt_tok_if #(
	parameter int LINE_BITS   = 20,
	parameter int OFFSET_BITS = 24,
	parameter int LENGTH_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [4:0]             token_kind;
	logic [LINE_BITS-1:0]   token_line;
	logic [OFFSET_BITS-1:0] token_start;
	logic [LENGTH_BITS-1:0] token_length;
	logic [7:0]             bad_char;
	logic                   last_of_run;

	modport source (output valid, token_kind, token_line, token_start, token_length,
		bad_char, last_of_run, input ready);
	modport sink (input valid, token_kind, token_line, token_start, token_length,
		bad_char, last_of_run, output ready);
endinterface
`default_nettype wire

### sv/stt_queue.sv
// stt_queue: small first-word-fall-through queue of token bundles
`default_nettype none
module stt_queue
	import stt_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output logic      [WIDTH-1:0] head_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_data  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### sv/stt_front.sv
// stt_front: takes source bytes, runs the scan state and builds token bundles
`default_nettype none
module stt_front
	import stt_pkg::*;
#(
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
	parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int LINE_BITS     = LINE_BITS_DEF,
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	localparam int TOK_W = KIND_W + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 8,
	localparam int BUN_W = 2 + 3 * TOK_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	stt_req_if.sink               req,
	output logic                  push,
	output logic      [BUN_W-1:0] push_data,
	input  wire logic             full
);
	localparam int KB_IW = $clog2(KEYWORD_CHARS);
	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [LINE_BITS-1:0]   line;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] length;
		logic [7:0]             bad;
	} tok_t;

	typedef struct packed {
		logic [1:0]     ntok;
		tok_t [2:0]     t;
	} bundle_t;

	logic [MODE_W-1:0]      mode_q, mode_d;
	logic [7:0]             kbuf_q [KEYWORD_CHARS];
	logic                   long_q, long_d;
	logic [LENGTH_BITS-1:0] vlen_q, vlen_d;
	logic [OFFSET_BITS-1:0] vstart_q, vstart_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [OFFSET_BITS-1:0] dot_q, dot_d;

	logic                   kb_we;
	logic [KB_IW-1:0]       kb_idx;
	logic [7:0]             c;
	logic                   accept, is_end, is_let, is_dig, is_ws, is_nl;
	logic                   flush, fresh;
	logic [1:0]             n;
	tok_t [2:0]             t;
	bundle_t                bun;
	logic [63:0]            kw_text;
	logic [3:0]             kw_len;
	logic [KIND_W-1:0]      id_kind, sk;
	logic [LENGTH_BITS-1:0] vlen_inc;
	logic [LINE_BITS-1:0]   line_inc;
	logic [OFFSET_BITS-1:0] off_inc;

	assign req.ready = !full;
	assign accept    = req.valid && !full;
	assign c         = req.char_byte;
	assign is_end    = req.req_type || c == 8'd0;
	assign is_let    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	assign is_dig    = c >= "0" && c <= "9";
	assign is_ws     = c == " " || (c >= 8'd9 && c <= 8'd13);
	assign is_nl     = c == 8'd10;
	assign sk        = single_kind(c);

	assign vlen_inc = (vlen_q == LEN_MAX) ? vlen_q : vlen_q + 1'b1;
	assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
	assign off_inc  = (off_q == OFF_MAX) ? off_q : off_q + 1'b1;

	always_comb begin
		kw_text = '0;
		for (int i = 0; i < 8; i++) begin
			kw_text[63 - 8 * i -: 8] = kbuf_q[i];
		end
		kw_len  = (vlen_q <= LENGTH_BITS'(8)) ? vlen_q[3:0] : 4'd0;
		id_kind = long_q ? K_ID : kw_lookup(kw_text, kw_len);
	end

	always_comb begin
		mode_d   = mode_q;
		long_d   = long_q;
		vlen_d   = vlen_q;
		vstart_d = vstart_q;
		off_d    = is_end ? off_q : off_inc;
		line_d   = line_q;
		dot_d    = dot_q;
		kb_we    = 1'b0;
		kb_idx   = '0;
		flush    = 1'b0;
		fresh    = 1'b0;
		n        = 2'd0;
		t        = '0;

		if (is_end) begin
			flush = 1'b1;
		end else begin
			unique case (mode_q)
				M_IDENT: begin
					if (is_let || is_dig) begin
						if (vlen_q < LENGTH_BITS'(KEYWORD_CHARS)) begin
							kb_we  = 1'b1;
							kb_idx = vlen_q[KB_IW-1:0];
						end else begin
							long_d = 1'b1;
						end
						vlen_d = vlen_inc;
					end else begin
						flush = 1'b1;
						fresh = 1'b1;
					end
				end
				M_INT: begin
					if (is_dig) begin
						vlen_d = vlen_inc;
					end else if (c == ".") begin
						dot_d  = off_q;
						mode_d = M_DOT;
					end else begin
						flush = 1'b1;
						fresh = 1'b1;
					end
				end
				M_DOT: begin
					if (is_dig) begin
						vlen_d = (vlen_inc == LEN_MAX) ? vlen_inc : vlen_inc + 1'b1;
						mode_d = M_FRAC;
					end else begin
						flush = 1'b1;
						fresh = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_dig) begin
						vlen_d = vlen_inc;
					end else begin
						flush = 1'b1;
						fresh = 1'b1;
					end
				end
				M_STR: begin
					if (c == "\"") begin
						t[0]   = '{K_STR, line_q, vstart_q, vlen_q, 8'd0};
						n      = 2'd1;
						mode_d = M_IDLE;
					end else begin
						if (is_nl) begin
							line_d = line_inc;
						end
						vlen_d = vlen_inc;
					end
				end
				M_CMT: begin
					if (is_nl) begin
						line_d = line_inc;
						mode_d = M_IDLE;
					end
				end
				M_SLASH: begin
					if (c == "/") begin
						mode_d = M_CMT;
					end else begin
						flush = 1'b1;
						fresh = 1'b1;
					end
				end
				M_EQ, M_BANG, M_LT, M_GT: begin
					if (c == "=") begin
						t[0].kind   = (mode_q == M_EQ) ? K_EQ : (mode_q == M_BANG) ? K_NE :
							(mode_q == M_LT) ? K_LE : K_GE;
						t[0].line   = line_q;
						t[0].start  = vstart_q;
						t[0].length = LENGTH_BITS'(2);
						n           = 2'd1;
						mode_d      = M_IDLE;
					end else begin
						flush = 1'b1;
						fresh = 1'b1;
					end
				end
				default: begin
					fresh = 1'b1;
				end
			endcase
		end

		if (flush) begin
			unique case (mode_q)
				M_IDENT: begin
					t[n] = '{id_kind, line_q, vstart_q, vlen_q, 8'd0};
					n    = n + 2'd1;
				end
				M_INT, M_FRAC: begin
					t[n] = '{K_NUM, line_q, vstart_q, vlen_q, 8'd0};
					n    = n + 2'd1;
				end
				M_DOT: begin
					t[n] = '{K_NUM, line_q, vstart_q, vlen_q, 8'd0};
					n    = n + 2'd1;
					t[n] = '{K_ERR, line_q, dot_q, LENGTH_BITS'(1), "."};
					n    = n + 2'd1;
				end
				M_STR: begin
					t[n] = '{K_STR, line_q, vstart_q, vlen_q, 8'd0};
					n    = n + 2'd1;
				end
				M_SLASH: begin
					t[n] = '{K_DIV, line_q, vstart_q, LENGTH_BITS'(1), 8'd0};
					n    = n + 2'd1;
				end
				M_EQ: begin
					t[n] = '{K_ASSIGN, line_q, vstart_q, LENGTH_BITS'(1), 8'd0};
					n    = n + 2'd1;
				end
				M_LT: begin
					t[n] = '{K_LT, line_q, vstart_q, LENGTH_BITS'(1), 8'd0};
					n    = n + 2'd1;
				end
				M_GT: begin
					t[n] = '{K_GT, line_q, vstart_q, LENGTH_BITS'(1), 8'd0};
					n    = n + 2'd1;
				end
				M_BANG: begin
					t[n] = '{K_ERR, line_q, vstart_q, LENGTH_BITS'(1), "!"};
					n    = n + 2'd1;
				end
				default: begin
				end
			endcase
			mode_d = M_IDLE;
		end

		if (fresh) begin
			mode_d = M_IDLE;
			if (is_ws) begin
				if (is_nl) begin
					line_d = line_inc;
				end
			end else if (is_let) begin
				vstart_d = off_q;
				vlen_d   = LENGTH_BITS'(1);
				kb_we    = 1'b1;
				kb_idx   = '0;
				long_d   = 1'b0;
				mode_d   = M_IDENT;
			end else if (is_dig) begin
				vstart_d = off_q;
				vlen_d   = LENGTH_BITS'(1);
				mode_d   = M_INT;
			end else if (c == "\"") begin
				vstart_d = off_inc;
				vlen_d   = '0;
				mode_d   = M_STR;
			end else if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">") begin
				vstart_d = off_q;
				mode_d   = (c == "/") ? M_SLASH : (c == "=") ? M_EQ : (c == "!") ? M_BANG :
					(c == "<") ? M_LT : M_GT;
			end else if (sk != K_END) begin
				t[n] = '{sk, line_q, off_q, LENGTH_BITS'(1), 8'd0};
				n    = n + 2'd1;
			end else begin
				t[n] = '{K_ERR, line_q, off_q, LENGTH_BITS'(1), c};
				n    = n + 2'd1;
			end
		end

		if (is_end) begin
			t[n]     = '{K_END, line_q, off_q, '0, 8'd0};
			n        = n + 2'd1;
			mode_d   = M_IDLE;
			long_d   = 1'b0;
			vlen_d   = '0;
			vstart_d = '0;
			off_d    = '0;
			line_d   = LINE_BITS'(1);
			dot_d    = '0;
		end
	end

	assign bun.ntok  = n;
	assign bun.t     = t;
	assign push      = accept && n != 2'd0;
	assign push_data = bun;

	always_ff @(posedge clk) begin
		if (accept && kb_we) begin
			kbuf_q[kb_idx] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			long_q   <= 1'b0;
			vlen_q   <= '0;
			vstart_q <= '0;
			off_q    <= '0;
			line_q   <= LINE_BITS'(1);
			dot_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			long_q   <= long_d;
			vlen_q   <= vlen_d;
			vstart_q <= vstart_d;
			off_q    <= off_d;
			line_q   <= line_d;
			dot_q    <= dot_d;
		end
	end
endmodule
`default_nettype wire

### sv/stt_back.sv
// stt_back: unpacks token bundles into single tokens behind an output register
`default_nettype none
module stt_back
	import stt_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LINE_BITS   = LINE_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	localparam int TOK_W = KIND_W + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 8,
	localparam int BUN_W = 2 + 3 * TOK_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire logic [BUN_W-1:0] head_data,
	output logic                  pop,
	stt_tok_if.source             tok
);
	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [LINE_BITS-1:0]   line;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] length;
		logic [7:0]             bad;
	} tok_t;

	typedef struct packed {
		logic [1:0]     ntok;
		tok_t [2:0]     t;
	} bundle_t;

	bundle_t    head;
	tok_t       cur;
	logic [1:0] idx_q;
	logic       load, last;
	logic       valid_q;
	tok_t       out_q;
	logic       last_q;

	assign head = head_data;
	assign cur  = head.t[idx_q];
	assign last = idx_q == head.ntok - 2'd1;
	assign load = head_valid && (!valid_q || tok.ready);
	assign pop  = load && last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= cur;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (tok.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign tok.valid        = valid_q;
	assign tok.token_kind   = out_q.kind;
	assign tok.token_line   = out_q.line;
	assign tok.token_start  = out_q.start;
	assign tok.token_length = out_q.length;
	assign tok.bad_char     = out_q.bad;
	assign tok.last_of_run  = last_q;
endmodule
`default_nettype wire

### sv/source_text_tokenizer_top.sv
// source_text_tokenizer_top: streaming lexer, byte requests in, tokens out
//
//  channel  dir  payload                                              handshake
//  req      in   req_type, char_byte                                  valid/ready
//  tok      out  token_kind, token_line, token_start, token_length,   valid/ready
//                bad_char, last_of_run
//
// one request is taken per cycle while the bundle queue has room; the scan
// state updates in that same cycle, so the front runs at one byte per cycle
// each request yields zero to three tokens, which leave one per cycle from the
// output register while tok is ready; a request with k tokens holds the output
// side until all k have left; reset is asynchronous and needs no clearing pass
// a stalled tok side fills the queue, then req.ready drops
`default_nettype none
module source_text_tokenizer_top
	import stt_pkg::*;
#(
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
	parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int LINE_BITS     = LINE_BITS_DEF,
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_req_if.sink   req,
	stt_tok_if.source tok
);
	localparam int TOK_W = KIND_W + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 8;
	localparam int BUN_W = 2 + 3 * TOK_W;

	logic             push, full, pop, head_valid;
	logic [BUN_W-1:0] push_data, head_data;

	stt_front #(
		.KEYWORD_CHARS (KEYWORD_CHARS),
		.OFFSET_BITS   (OFFSET_BITS),
		.LINE_BITS     (LINE_BITS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	stt_queue #(
		.WIDTH (BUN_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	stt_back #(
		.OFFSET_BITS (OFFSET_BITS),
		.LINE_BITS   (LINE_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.tok        (tok)
	);
endmodule
`default_nettype wire
